// ===== rtl/sliding_window_minimum_top_macros.svh =====
// Assertion macros for the sliding window minimum block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SLIDING_WINDOW_MINIMUM_TOP_MACROS_SVH
`define SLIDING_WINDOW_MINIMUM_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
`default_nettype none

package swm_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int WIN_W  = 7;

  // Default depth of the cell chain
  localparam int WINDOW_MAX_DEF = 64;

  // Register port
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [WIN_W-1:0]  WINDOW_RESET    = 7'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_min;
    logic                     end_of_sequence;
  } out_item_t;

  // Control shared by every cell in the chain
  typedef struct packed {
    logic advance;
    logic flush;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_minimum_top.sv =====
// A result is held in the pending flag pend_r and then loaded into the output register.
// Throughput: one sample per cycle while in_stall is low; the cell chain shifts once per transaction.
// The input stalls only while a result waits and the output register is stalled.
// Reset (synchronous, rst_n low): all cells empty, count zero, window_size = 1.
// A sample marked last empties the chain at the next accepted sample.
`default_nettype none

module sliding_window_minimum_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire swm_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output swm_pkg::out_item_t                out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [swm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [swm_pkg::APB_DW-1:0]   pwdata,
  output logic [swm_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (KW > swm_pkg::WIN_W) ? KW : swm_pkg::WIN_W;

  logic [swm_pkg::WIN_W-1:0]         window_size_r;
  logic [CW-1:0]                     ws_ext;
  logic [CW-1:0]                     k_wide;
  logic [KW-1:0]                     k_eff;
  logic [KW-1:0]                     seen_r;
  logic [KW-1:0]                     seen_nxt;
  logic [KW-1:0]                     seen_base;
  logic [KW:0]                       seen_inc;
  logic                              flush_r;
  logic                              pend_r;
  logic                              pend_last_r;
  logic                              emit;
  logic                              in_accept;
  logic                              load_out;
  logic                              out_valid_r;
  swm_pkg::out_item_t                out_data_r;
  swm_pkg::cell_ctrl_t               ctrl;
  logic [WINDOW_MAX-1:0]             cand_r;
  logic [WINDOW_MAX-1:0]             pick;
  logic signed [swm_pkg::DATA_W-1:0] cell_value [WINDOW_MAX];
  logic signed [swm_pkg::DATA_W-1:0] min_value;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swm_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[swm_pkg::ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE)) begin
      window_size_r <= pwdata[swm_pkg::WIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[swm_pkg::ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE) begin
      prdata = {{(swm_pkg::APB_DW - swm_pkg::WIN_W){1'b0}}, window_size_r};
    end
  end

  // Clamp the window into 1..WINDOW_MAX
  always_comb begin
    ws_ext = CW'(window_size_r);
    if (ws_ext == '0) begin
      k_wide = CW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      k_wide = CW'(WINDOW_MAX);
    end else begin
      k_wide = ws_ext;
    end
    k_eff = k_wide[KW-1:0];
  end

  // Handshake: hold the input only while a result cannot move to the output
  assign in_stall  = pend_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign load_out  = pend_r && (!out_valid_r || !out_stall);

  // Saturating sample count; a finished sequence restarts from zero
  always_comb begin
    seen_base = flush_r ? '0 : seen_r;
    seen_inc  = {1'b0, seen_base} + (KW + 1)'(1);
    seen_nxt  = (seen_inc > {1'b0, k_eff}) ? k_eff : seen_inc[KW-1:0];
    emit      = (seen_nxt == k_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      flush_r     <= 1'b0;
      pend_r      <= 1'b0;
    end else if (in_accept) begin
      seen_r      <= seen_nxt;
      flush_r     <= in_data.last_sample;
      pend_r      <= emit;
    end else if (load_out) begin
      pend_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_last_r <= in_data.last_sample;
    end
  end

  // Cell chain
  assign ctrl.advance = in_accept;
  assign ctrl.flush   = flush_r;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_first
      swm_cell #(.KW(KW), .IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .k          (k_eff),
        .sample     (in_data.sample),
        .prev_value (in_data.sample),
        .prev_cand  (1'b0),
        .value_r    (cell_value[i]),
        .cand_r     (cand_r[i])
      );
    end else begin : g_next
      swm_cell #(.KW(KW), .IDX(i)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .k          (k_eff),
        .sample     (in_data.sample),
        .prev_value (cell_value[i-1]),
        .prev_cand  (cand_r[i-1]),
        .value_r    (cell_value[i]),
        .cand_r     (cand_r[i])
      );
    end
  end

  // Oldest candidate is the window minimum
  swm_select #(.N(WINDOW_MAX)) u_select (
    .cand      (cand_r),
    .values    (cell_value),
    .min_value (min_value),
    .pick      (pick)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.window_min      <= min_value;
      out_data_r.end_of_sequence <= pend_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `include "sliding_window_minimum_top_macros.svh"

  `SWM_ASSERT_SAME(a_stall_while_blocked, pend_r && out_valid_r && out_stall, in_stall, "input taken while a result is blocked")
  `SWM_ASSERT_NEXT(a_head_cand, in_accept, cand_r[0], "newest sample is not a candidate")
  `SWM_ASSERT_NEXT(a_flush_after_last, in_accept && in_data.last_sample, flush_r, "last sample did not mark the chain for flush")
  `SWM_ASSERT_SAME(a_pick_one, pend_r, $onehot(pick), "pending result without exactly one candidate picked")

endmodule

`default_nettype wire

// ===== rtl/swm_cell.sv =====
`default_nettype none

module swm_cell #(
  parameter int KW  = 7,
  parameter int IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire swm_pkg::cell_ctrl_t              ctrl,
  input  wire logic [KW-1:0]                    k,
  input  wire logic signed [swm_pkg::DATA_W-1:0] sample,
  input  wire logic signed [swm_pkg::DATA_W-1:0] prev_value,
  input  wire logic                             prev_cand,
  output logic signed [swm_pkg::DATA_W-1:0]     value_r,
  output logic                                  cand_r
);

  logic signed [swm_pkg::DATA_W-1:0] value_nxt;
  logic                              cand_nxt;

  // Head cell takes the new sample; the others take their neighbor's entry
  // and keep it as a candidate only if it was one, no flush is pending, it is newer
  // than the window edge and it is strictly below the new sample.
  if (IDX == 0) begin : g_head
    always_comb begin
      value_nxt = sample;
      cand_nxt  = 1'b1;
    end
  end else begin : g_body
    always_comb begin
      value_nxt = prev_value;
      cand_nxt  = prev_cand && !ctrl.flush && (prev_value < sample) && (KW'(IDX) < k);
    end
  end

  // Advance on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= 1'b0;
    end else if (ctrl.advance) begin
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      value_r <= value_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swm_select.sv =====
`default_nettype none

module swm_select #(
  parameter int N = 64
) (
  input  wire logic [N-1:0]                      cand,
  input  wire logic signed [swm_pkg::DATA_W-1:0] values [N],
  output logic signed [swm_pkg::DATA_W-1:0]      min_value,
  output logic [N-1:0]                           pick
);

  // Pick the oldest candidate: the highest position with its flag set
  always_comb begin
    logic older;
    older = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      pick[i] = cand[i] && !older;
      older   = older || cand[i];
    end
  end

  // Merge the picked entry onto the result
  always_comb begin
    min_value = '0;
    for (int i = 0; i < N; i++) begin
      min_value = min_value | (pick[i] ? values[i] : '0);
    end
  end

endmodule

`default_nettype wire

// ===== sim/swm_checker.sv =====
`timescale 1ns / 100ps

// Track the sliding window minimum alongside the block and compare every result.
module swm_checker
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending_count
);

  localparam int AGE_MAX     = 127;
  localparam int MAX_REPORTS = 10;
  localparam logic [ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [WIN_W-1:0]         age;
  } candidate_t;

  candidate_t       candidates[$];     // oldest first, values strictly rising
  out_item_t        expected_mins[$];
  logic [WIN_W-1:0] window_size;
  int               seen_count;
  int               mismatches;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    mismatches    = 0;
    seen_count    = 0;
    window_size   = WINDOW_RESET;
  end

  // Clamp the programmed window into 1..WINDOW_MAX
  function automatic int effective_window(logic [WIN_W-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return w;
  endfunction

  // Age and prune the candidates, append the new sample, queue any result
  function automatic void slide_window(in_item_t item);
    candidate_t kept[$];
    candidate_t cand;
    out_item_t  exp_item;
    int         k;
    k = effective_window(window_size);
    foreach (candidates[i]) begin
      cand = candidates[i];
      if (cand.age < AGE_MAX) cand.age = cand.age + 1'b1;
      if (cand.age < k && $signed(cand.value) < $signed(item.sample)) kept = {kept, cand};
    end
    cand.value = item.sample;
    cand.age   = '0;
    kept = {kept, cand};
    candidates = kept;

    seen_count = (seen_count + 1 > k) ? k : seen_count + 1;
    if (seen_count >= k) begin
      exp_item.window_min      = candidates[0].value;
      exp_item.end_of_sequence = item.last_sample;
      expected_mins = {expected_mins, exp_item};
    end

    // A last sample empties the window whether or not it produced a result
    if (item.last_sample) begin
      candidates.delete();
      seen_count = 0;
    end
  endfunction

  function automatic void note_fail(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      candidates.delete();
      expected_mins.delete();
      seen_count  = 0;
      window_size = WINDOW_RESET;
    end else begin
      // Follow register writes
      if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
        window_size = pwdata[WIN_W-1:0];

      if (in_valid && !in_stall) slide_window(in_data);

      // Compare each result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_mins.size() == 0) begin
          note_fail($sformatf("unexpected result window_min=%0d end_of_sequence=%0b",
                              $signed(out_data.window_min), out_data.end_of_sequence));
        end else begin
          want = expected_mins.pop_front();
          if (out_data.window_min !== want.window_min)
            note_fail($sformatf("window_min expected %0d, got %0d",
                                $signed(want.window_min), $signed(out_data.window_min)));
          if (out_data.end_of_sequence !== want.end_of_sequence)
            note_fail($sformatf("end_of_sequence expected %0b, got %0b",
                                want.end_of_sequence, out_data.end_of_sequence));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_mins.size();
  end

endmodule

// ===== sim/sliding_window_minimum_top_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_minimum_top_tb;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int ITEM_TARGET = 1120;
  localparam int LONG_HOLD   = 300;
  localparam logic [ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_RISE,
    SHAPE_FALL,
    SHAPE_EXTREME
  } shape_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int items_sent   = 0;
  int cycle_count  = 0;
  bit steady       = 1'b0;  // no idling on either side
  bit hold_off_req = 1'b0;  // ask the receiver for one long stall

  sliding_window_minimum_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  swm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Offer one sample after an optional gap and hold it until accepted
  task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{sample: value, last_sample: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    // samples that produce no result may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    paddr   <= WINDOW_ADDR;
    pwdata  <= APB_DW'(w);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One run of samples with a random shape; noisy runs drop stray last flags
  task automatic run_sequence(input int len, input bit closes, input bit noisy);
    shape_t                   shape;
    logic signed [DATA_W-1:0] level;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    shape = shape_t'($urandom_range(SHAPE_NOISE, SHAPE_EXTREME));
    level = $urandom;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE:  value = $urandom;
        SHAPE_NARROW: value = int'($urandom_range(0, 8)) - 4;
        SHAPE_RISE: begin
          level = level + $urandom_range(0, 3);
          value = level;
        end
        SHAPE_FALL: begin
          level = level - $urandom_range(0, 3);
          value = level;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7FFF_FFFF;
            2:       value = '0;
            default: value = -1;
          endcase
        end
      endcase
      last = (closes && i == len - 1) || (noisy && $urandom_range(0, 9) == 0);
      send_sample(value, last);
    end
  endtask

  // Program a window, then stream sequences sized around it
  task automatic run_phase(input logic [WIN_W-1:0] w, input bit hold_first);
    int k;
    int stop_at;
    int len;
    wait_results_drained();
    write_window(w);
    // back up the block while the sender keeps offering
    if (hold_first) hold_off_req = 1'b1;
    k = (w == 0) ? 1 : (w > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : w;
    stop_at = items_sent + ((k > 16) ? 220 : 80);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7)
        len = $urandom_range((k > 2) ? k - 2 : 1, k + 6);
      else
        len = $urandom_range(1, 2 * k + 8);
      run_sequence(len, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 15);
    end
  endtask

  initial begin : stimulus
    int               phase;
    logic [WIN_W-1:0] w;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of one: every sample is its own minimum
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);

    // Window of three with equal values and both extremes
    wait_results_drained();
    write_window(3);
    send_sample(5, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(0, 1'b1);

    // Sequence shorter than the window: no result, state still clears
    send_sample(9, 1'b0);
    send_sample(8, 1'b1);

    // Shrink the window in the middle of a rising sequence
    wait_results_drained();
    write_window(4);
    send_sample(10, 1'b0);
    send_sample(20, 1'b0);
    send_sample(30, 1'b0);
    send_sample(40, 1'b0);
    send_sample(50, 1'b0);
    wait_results_drained();
    write_window(2);
    send_sample(60, 1'b0);
    send_sample(5, 1'b1);

    // Random phases: the extremes first, then mostly small windows
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       w = 7'd0;
        1:       w = 7'd127;
        2:       w = 7'd64;
        3:       w = 7'd2;
        4:       w = 7'd65;
        5:       w = 7'd1;
        default: w = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom_range(1, 64))
                                                  : WIN_W'($urandom_range(1, 12));
      endcase
      steady = (phase % 4 == 3);
      run_phase(w, phase == 3);
      phase++;
    end
    steady = 1'b0;

    wait_results_drained();
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
